FILE: rtl/spid_pkg.sv
// ----------------------------------------------------------------------------
// spid_pkg: shared types and constants of the saturating PID controller
// Widths, limits, register indexes and the multiply/divide unit handshake.
// ----------------------------------------------------------------------------
package spid_pkg;

  localparam int DATA_W    = 16;          // reference, measurement, drive
  localparam int GAIN_W    = 15;          // gain registers
  localparam int CFG_IDX_W = 2;           // config register index
  localparam int ERR_W     = DATA_W + 1;  // difference of two samples
  localparam int LI_W      = 30;          // integral limit, also divide quotient
  localparam int ACC_W     = LI_W + GAIN_W;
  localparam int TERM_W    = 31;          // magnitude of one PID term
  localparam int TOT_W     = TERM_W + 3;  // signed sum of three terms
  localparam int CAND_W    = 33;          // error_sum + error
  localparam int ES_W      = 32;          // error_sum
  localparam int CNT_W     = 5;           // iteration counter of the unit
  localparam int DIV_SHIFT = 7;           // divide by 128
  localparam int Q_W       = TOT_W - DIV_SHIFT;

  localparam logic [TERM_W-1:0] MAX32      = 31'h7FFF_FFFF;
  localparam logic [TERM_W-1:0] HALF_MAX32 = 31'h3FFF_FFFF;
  // floor(MAX32 / 2): dividend of the integral limit division
  localparam logic [LI_W-1:0]   LI_RESET   = 30'h3FFF_FFFF;
  localparam logic [DATA_W-1:0] MAX16      = 16'h7FFF;
  localparam logic [DIV_SHIFT-1:0] RND_BIAS = '1;

  localparam logic [CFG_IDX_W-1:0] REG_PGAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DGAIN = 2'd2;

  typedef enum logic {
    MDU_MUL = 1'b0,
    MDU_DIV = 1'b1
  } mdu_op_t;

  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mdu_sts_t;

endpackage

FILE: rtl/spid_in_if.sv
// ----------------------------------------------------------------------------
// spid_in_if: input item channel
// Reference and measured position with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface spid_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [spid_pkg::DATA_W-1:0]  reference;
  logic signed [spid_pkg::DATA_W-1:0]  measurement;

  modport source (output valid, output reference, output measurement, input ready);
  modport sink   (input valid, input reference, input measurement, output ready);
endinterface

FILE: rtl/spid_out_if.sv
// ----------------------------------------------------------------------------
// spid_out_if: result item channel
// Drive value with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface spid_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [spid_pkg::DATA_W-1:0]  drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

FILE: rtl/spid_cfg_if.sv
// ----------------------------------------------------------------------------
// spid_cfg_if: configuration write channel
// Register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface spid_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [spid_pkg::CFG_IDX_W-1:0]      index;
  logic [spid_pkg::GAIN_W-1:0]         wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

FILE: rtl/spid_mdu.sv
// ----------------------------------------------------------------------------
// spid_mdu: iterative multiply / divide unit
// One adder, one bit per cycle: shift-add multiply of a 30-bit magnitude by a
// 15-bit gain, or restoring division of floor(MAX32/2) by a 16-bit divisor.
// ----------------------------------------------------------------------------
module spid_mdu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  spid_pkg::mdu_req_t            req,
  input  logic [spid_pkg::LI_W-1:0]     opa,   // multiplicand or divisor
  input  logic [spid_pkg::GAIN_W-1:0]   opb,   // multiplier
  output spid_pkg::mdu_sts_t            sts,
  output logic [spid_pkg::ACC_W-1:0]    prod,
  output logic [spid_pkg::LI_W-1:0]     quo
);

  logic                          busy_r;
  spid_pkg::mdu_op_t             op_r;
  logic [spid_pkg::CNT_W-1:0]    cnt_r;
  logic [spid_pkg::ACC_W-1:0]    acc_r;
  logic [spid_pkg::LI_W-1:0]     opa_r;
  logic [spid_pkg::LI_W-1:0]     sh_r;

  logic                          is_div;
  logic                          step;
  logic [spid_pkg::ACC_W-1:0]    add_a;
  logic [spid_pkg::ACC_W-1:0]    addend;
  logic [spid_pkg::ACC_W-1:0]    add_b;
  logic [spid_pkg::ACC_W:0]      add_sum;
  logic                          div_ok;

  assign is_div  = (op_r == spid_pkg::MDU_DIV);
  assign step    = busy_r && (cnt_r != '0);
  // division shifts in a one each step: the dividend is all ones
  assign add_a   = {acc_r[spid_pkg::ACC_W-2:0], is_div};
  assign addend  = spid_pkg::ACC_W'(opa_r);
  assign add_b   = is_div ? ~addend :
                   (sh_r[spid_pkg::GAIN_W-1] ? addend : '0);
  assign add_sum = {1'b0, add_a} + {1'b0, add_b} + (spid_pkg::ACC_W+1)'(is_div);
  assign div_ok  = add_sum[spid_pkg::ACC_W];  // no borrow: remainder >= divisor

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
      op_r   <= spid_pkg::MDU_MUL;
    end else if (req.start) begin
      busy_r <= 1'b1;
      op_r   <= req.op;
      cnt_r  <= (req.op == spid_pkg::MDU_DIV) ? spid_pkg::CNT_W'(spid_pkg::LI_W)
                                              : spid_pkg::CNT_W'(spid_pkg::GAIN_W);
    end else if (step) begin
      cnt_r <= cnt_r - 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc_r <= '0;
      opa_r <= opa;
      sh_r  <= (req.op == spid_pkg::MDU_DIV) ? '0 : spid_pkg::LI_W'(opb);
    end else if (step) begin
      if (is_div) begin
        acc_r <= div_ok ? add_sum[spid_pkg::ACC_W-1:0] : add_a;
        sh_r  <= {sh_r[spid_pkg::LI_W-2:0], div_ok};
      end else begin
        acc_r <= add_sum[spid_pkg::ACC_W-1:0];
        sh_r  <= {sh_r[spid_pkg::LI_W-2:0], 1'b0};
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = busy_r && (cnt_r == '0);
  assign prod     = acc_r;
  assign quo      = sh_r;

endmodule

FILE: rtl/saturating_pid_controller_core.sv
// ----------------------------------------------------------------------------
// saturating_pid_controller_core: PID position controller with anti-windup
// Proportional, clamped integral and derivative terms summed at full width,
// divided by 128 toward zero and clamped to +/-32767.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  ----------------------------------------
//  cfg_ch   in   valid/ready          index[1:0], wdata[14:0] (P, I, D gain)
//  in_ch    in   valid/ready          reference[15:0], measurement[15:0]
//  out_ch   out  valid/ready          drive[15:0]
//
//  - The result is valid once the P, I and D multiplies, of 15 steps each in
//    the shared unit, are done; the I multiply is skipped when the integral
//    sum clamps. The next item is taken only after the result is written.
//  - A write of the integral gain makes the unit divide floor(MAX32/2) by
//    (I+1) for the integral limit, one bit a cycle.
//  - in_ch and cfg_ch are ready only while the sequencer is idle; a config
//    write wins over an item offered in the same cycle.
//  - The result sits in an output register; the next item is accepted while
//    it waits, and only the final write stalls on a full output register.
//  - Synchronous active-low reset clears gains, error sum, last measurement,
//    and sets the integral limit to its value for a zero gain.
// ----------------------------------------------------------------------------
module saturating_pid_controller_core (
  input  logic        clk,
  input  logic        rst_n,
  spid_cfg_if.sink    cfg_ch,
  spid_in_if.sink     in_ch,
  spid_out_if.source  out_ch
);

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_LIMIT = 7'b0000010,  // integral limit division
    ST_PMUL  = 7'b0000100,  // P * |error|
    ST_ICHK  = 7'b0001000,  // integral clamp decision
    ST_IMUL  = 7'b0010000,  // I * |error_sum|
    ST_DMUL  = 7'b0100000,  // D * |prev - meas|
    ST_OUT   = 7'b1000000
  } state_t;

  localparam int DW = spid_pkg::DATA_W;

  // sign-applied term at sum width
  function automatic logic signed [spid_pkg::TOT_W-1:0] sterm(
    input logic [spid_pkg::TERM_W-1:0] mag,
    input logic                        neg
  );
    logic signed [spid_pkg::TOT_W-1:0] ext;
    ext = $signed(spid_pkg::TOT_W'(mag));
    return neg ? -ext : ext;
  endfunction

  // control state
  state_t                               state_r, state_nxt;
  logic [spid_pkg::GAIN_W-1:0]          p_gain_r, p_gain_nxt;
  logic [spid_pkg::GAIN_W-1:0]          i_gain_r, i_gain_nxt;
  logic [spid_pkg::GAIN_W-1:0]          d_gain_r, d_gain_nxt;
  logic [spid_pkg::LI_W-1:0]            li_r, li_nxt;
  logic signed [spid_pkg::ES_W-1:0]     error_sum_r, error_sum_nxt;
  logic signed [DW-1:0]                 prev_r, prev_nxt;
  logic                                 out_valid_r, out_valid_nxt;

  // per-item payload
  logic signed [spid_pkg::ERR_W-1:0]    err_r, err_nxt;
  logic [spid_pkg::ERR_W-1:0]           err_mag_r, err_mag_nxt;
  logic                                 dm_neg_r, dm_neg_nxt;
  logic [spid_pkg::ERR_W-1:0]           dm_mag_r, dm_mag_nxt;
  logic signed [spid_pkg::CAND_W-1:0]   cand_r, cand_nxt;
  logic signed [spid_pkg::TOT_W-1:0]    tot_r, tot_nxt;
  logic signed [DW-1:0]                 out_drive_r, out_drive_nxt;

  // shared unit
  spid_pkg::mdu_req_t                   mdu_req;
  spid_pkg::mdu_sts_t                   mdu_sts;
  logic [spid_pkg::LI_W-1:0]            mdu_opa;
  logic [spid_pkg::GAIN_W-1:0]          mdu_opb;
  logic [spid_pkg::ACC_W-1:0]           mdu_prod;
  logic [spid_pkg::LI_W-1:0]            mdu_quo;

  // datapath
  logic                                 cfg_acc, in_acc, out_load;
  logic signed [spid_pkg::ERR_W-1:0]    err_in, dm_in;
  logic [spid_pkg::ACC_W:0]             p_chk;
  logic                                 p_sat;
  logic [spid_pkg::TERM_W-1:0]          p_mag;
  logic signed [spid_pkg::CAND_W-1:0]   li_s, cand_abs;
  logic                                 cand_hi, cand_lo;
  logic [spid_pkg::TERM_W-1:0]          prod_lo;
  logic signed [spid_pkg::TOT_W-1:0]    biased;
  logic signed [spid_pkg::Q_W-1:0]      quot;
  logic signed [spid_pkg::Q_W-1:0]      q_max;

  spid_mdu u_mdu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mdu_req),
    .opa   (mdu_opa),
    .opb   (mdu_opb),
    .sts   (mdu_sts),
    .prod  (mdu_prod),
    .quo   (mdu_quo)
  );

  // handshakes
  assign cfg_ch.ready = (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE) && !cfg_ch.valid;
  assign cfg_acc      = cfg_ch.valid && cfg_ch.ready;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_load     = (state_r == ST_OUT) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = out_drive_r;

  // error and measurement change of the incoming item
  assign err_in = spid_pkg::ERR_W'(in_ch.reference) - spid_pkg::ERR_W'(in_ch.measurement);
  assign dm_in  = spid_pkg::ERR_W'(prev_r) - spid_pkg::ERR_W'(in_ch.measurement);

  // P saturates when P*|e| + |e| = (P+1)*|e| exceeds MAX32
  assign p_chk   = {1'b0, mdu_prod} + (spid_pkg::ACC_W+1)'(err_mag_r);
  assign p_sat   = p_chk > (spid_pkg::ACC_W+1)'(spid_pkg::MAX32);
  assign prod_lo = mdu_prod[spid_pkg::TERM_W-1:0];
  assign p_mag   = p_sat ? spid_pkg::MAX32 : prod_lo;

  // integral window
  assign li_s     = $signed(spid_pkg::CAND_W'(li_r));
  assign cand_hi  = cand_r > li_s;
  assign cand_lo  = cand_r < -li_s;
  assign cand_abs = cand_r[spid_pkg::CAND_W-1] ? -cand_r : cand_r;

  // divide by 128 toward zero, then clamp
  assign biased = tot_r + (tot_r[spid_pkg::TOT_W-1] ?
                           $signed(spid_pkg::TOT_W'(spid_pkg::RND_BIAS)) : '0);
  assign quot   = $signed(biased[spid_pkg::TOT_W-1:spid_pkg::DIV_SHIFT]);
  assign q_max  = $signed(spid_pkg::Q_W'(spid_pkg::MAX16));

  always_comb begin
    state_nxt     = state_r;
    p_gain_nxt    = p_gain_r;
    i_gain_nxt    = i_gain_r;
    d_gain_nxt    = d_gain_r;
    li_nxt        = li_r;
    error_sum_nxt = error_sum_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r;
    err_nxt       = err_r;
    err_mag_nxt   = err_mag_r;
    dm_neg_nxt    = dm_neg_r;
    dm_mag_nxt    = dm_mag_r;
    cand_nxt      = cand_r;
    tot_nxt       = tot_r;
    out_drive_nxt = out_drive_r;
    mdu_req       = '{start: 1'b0, op: spid_pkg::MDU_MUL};
    mdu_opa       = '0;
    mdu_opb       = '0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (cfg_acc) begin
          unique case (cfg_ch.index)
            spid_pkg::REG_PGAIN: p_gain_nxt = cfg_ch.wdata;
            spid_pkg::REG_IGAIN: begin
              i_gain_nxt = cfg_ch.wdata;
              // new limit: floor(MAX32/2) / (I+1)
              mdu_req    = '{start: 1'b1, op: spid_pkg::MDU_DIV};
              mdu_opa    = spid_pkg::LI_W'(cfg_ch.wdata) + 1'b1;
              state_nxt  = ST_LIMIT;
            end
            spid_pkg::REG_DGAIN: d_gain_nxt = cfg_ch.wdata;
            default: ;  // no register there
          endcase
        end else if (in_acc) begin
          err_nxt     = err_in;
          err_mag_nxt = err_in[spid_pkg::ERR_W-1] ? spid_pkg::ERR_W'(-err_in)
                                                  : spid_pkg::ERR_W'(err_in);
          dm_neg_nxt  = dm_in[spid_pkg::ERR_W-1];
          dm_mag_nxt  = dm_in[spid_pkg::ERR_W-1] ? spid_pkg::ERR_W'(-dm_in)
                                                 : spid_pkg::ERR_W'(dm_in);
          prev_nxt    = in_ch.measurement;
          mdu_req     = '{start: 1'b1, op: spid_pkg::MDU_MUL};
          mdu_opa     = spid_pkg::LI_W'(err_mag_nxt);
          mdu_opb     = p_gain_r;
          state_nxt   = ST_PMUL;
        end
      end

      ST_LIMIT: begin
        if (mdu_sts.done) begin
          li_nxt    = mdu_quo;
          state_nxt = ST_IDLE;
        end
      end

      ST_PMUL: begin
        if (mdu_sts.done) begin
          tot_nxt   = sterm(p_mag, err_r[spid_pkg::ERR_W-1]);
          cand_nxt  = spid_pkg::CAND_W'(error_sum_r) + spid_pkg::CAND_W'(err_r);
          state_nxt = ST_ICHK;
        end
      end

      ST_ICHK: begin
        priority if (cand_hi) begin
          error_sum_nxt = $signed(spid_pkg::ES_W'(li_r));
          tot_nxt       = tot_r + sterm(spid_pkg::HALF_MAX32, 1'b0);
          mdu_req       = '{start: 1'b1, op: spid_pkg::MDU_MUL};
          mdu_opa       = spid_pkg::LI_W'(dm_mag_r);
          mdu_opb       = d_gain_r;
          state_nxt     = ST_DMUL;
        end else if (cand_lo) begin
          error_sum_nxt = -$signed(spid_pkg::ES_W'(li_r));
          tot_nxt       = tot_r + sterm(spid_pkg::HALF_MAX32, 1'b1);
          mdu_req       = '{start: 1'b1, op: spid_pkg::MDU_MUL};
          mdu_opa       = spid_pkg::LI_W'(dm_mag_r);
          mdu_opb       = d_gain_r;
          state_nxt     = ST_DMUL;
        end else begin
          // inside the window: |cand| <= limit < 2^30
          error_sum_nxt = cand_r[spid_pkg::ES_W-1:0];
          mdu_req       = '{start: 1'b1, op: spid_pkg::MDU_MUL};
          mdu_opa       = cand_abs[spid_pkg::LI_W-1:0];
          mdu_opb       = i_gain_r;
          state_nxt     = ST_IMUL;
        end
      end

      ST_IMUL: begin
        if (mdu_sts.done) begin
          // I*|cand| < 2^30 inside the window
          tot_nxt   = tot_r + sterm(prod_lo, cand_r[spid_pkg::CAND_W-1]);
          mdu_req   = '{start: 1'b1, op: spid_pkg::MDU_MUL};
          mdu_opa   = spid_pkg::LI_W'(dm_mag_r);
          mdu_opb   = d_gain_r;
          state_nxt = ST_DMUL;
        end
      end

      ST_DMUL: begin
        if (mdu_sts.done) begin
          tot_nxt   = tot_r + sterm(prod_lo, dm_neg_r);
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        if (out_load) begin
          priority if (quot > q_max) begin
            out_drive_nxt = $signed(spid_pkg::MAX16);
          end else if (quot < -q_max) begin
            out_drive_nxt = -$signed(spid_pkg::MAX16);
          end else begin
            out_drive_nxt = quot[DW-1:0];
          end
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      p_gain_r    <= '0;
      i_gain_r    <= '0;
      d_gain_r    <= '0;
      li_r        <= spid_pkg::LI_RESET;
      error_sum_r <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      p_gain_r    <= p_gain_nxt;
      i_gain_r    <= i_gain_nxt;
      d_gain_r    <= d_gain_nxt;
      li_r        <= li_nxt;
      error_sum_r <= error_sum_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r       <= err_nxt;
    err_mag_r   <= err_mag_nxt;
    dm_neg_r    <= dm_neg_nxt;
    dm_mag_r    <= dm_mag_nxt;
    cand_r      <= cand_nxt;
    tot_r       <= tot_nxt;
    out_drive_r <= out_drive_nxt;
  end

  // -------------------------------------------------------------------------
  // assertions
  // -------------------------------------------------------------------------
  a_ready_unit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.ready || cfg_ch.ready) |-> !mdu_sts.busy)
    else $error("port ready while the shared unit is still busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mdu_sts.done |-> (state_r == ST_LIMIT || state_r == ST_PMUL ||
                      state_r == ST_IMUL || state_r == ST_DMUL))
    else $error("unit finished outside a wait state");

  a_sum_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ICHK) |=>
      (error_sum_r <= $signed(spid_pkg::ES_W'(li_r)) &&
       error_sum_r >= -$signed(spid_pkg::ES_W'(li_r))))
    else $error("error sum left the integral window");

  a_out_written: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not placed in the output register");

  a_drive_sym: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_drive_r != -$signed(spid_pkg::MAX16) - 16'sd1))
    else $error("drive outside the symmetric range");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench of saturating_pid_controller_core
// Drives gain writes and reference/measurement items with random gaps and
// back-pressure, predicts each drive value in a local copy of the controller
// and compares every result item in order against that prediction.
// ----------------------------------------------------------------------------
module tb;

  // Controller arithmetic, at full width
  localparam longint FULL_SCALE = 64'sd2147483647;  // largest 32-bit signed value
  localparam longint DRIVE_LIM  = 64'sd32767;       // symmetric drive rail
  localparam longint DRIVE_DIV  = 64'sd128;

  // Index with no register behind it; writes there must change nothing
  localparam logic [spid_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam int RAND_PHASES    = 12;
  localparam int ITEMS_PER_PHASE = 88;

  typedef logic signed [spid_pkg::DATA_W-1:0] sample_t;
  typedef logic [spid_pkg::GAIN_W-1:0]        gain_t;

  logic clk = 1'b0;
  logic rst_n;

  spid_cfg_if cfg_bus ();
  spid_in_if  in_bus ();
  spid_out_if out_bus ();

  saturating_pid_controller_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_bus),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Local controller state: gains, integral sum, last measured position
  gain_t   kp, ki, kd;
  int      err_sum;
  sample_t last_meas;

  // Drive values predicted but not yet seen on the result channel
  sample_t drive_q[$];

  int items_sent, results_seen, mismatches, gain_writes, clamp_hits, rail_hits;
  bit no_idle;    // when set, neither side inserts gaps or stalls
  int track_pos;  // setpoint of the tracking-style random items

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Per-item wait of either side
  function automatic int draw_wait();
    return no_idle ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic sample_t to_sample(int v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return sample_t'(v);
  endfunction

  // One control step: returns the drive value and advances the local state.
  function automatic sample_t pid_drive(sample_t setpoint, sample_t position);
    longint err, lim_p, lim_i, p_term, i_term, d_term, cand, total, drv;
    err   = longint'(setpoint) - longint'(position);
    lim_p = FULL_SCALE / (longint'(kp) + 1);
    lim_i = FULL_SCALE / (2 * (longint'(ki) + 1));

    // proportional term saturates once (gain + 1) * error would pass full scale
    if (err > lim_p) p_term = FULL_SCALE;
    else if (err < -lim_p) p_term = -FULL_SCALE;
    else p_term = longint'(kp) * err;

    // anti-windup: the sum is held at the limit of the current gain
    cand = longint'(err_sum) + err;
    if (cand > lim_i) begin
      i_term  = FULL_SCALE / 2;
      err_sum = int'(lim_i);
      clamp_hits++;
    end else if (cand < -lim_i) begin
      i_term  = -(FULL_SCALE / 2);
      err_sum = int'(-lim_i);
      clamp_hits++;
    end else begin
      err_sum = int'(cand);
      i_term  = longint'(ki) * cand;
    end

    // derivative on measurement, not on error
    d_term    = longint'(kd) * (longint'(last_meas) - longint'(position));
    last_meas = position;

    // no wrap: sum at 64 bits, divide toward zero, then clamp
    total = p_term + i_term + d_term;
    drv   = total / DRIVE_DIV;
    if (drv > DRIVE_LIM) drv = DRIVE_LIM;
    else if (drv < -DRIVE_LIM) drv = -DRIVE_LIM;
    if (drv == DRIVE_LIM || drv == -DRIVE_LIM) rail_hits++;
    return sample_t'(drv);
  endfunction

  // Gain write; only issued once every predicted drive value has arrived.
  task automatic write_gain(logic [spid_pkg::CFG_IDX_W-1:0] idx, gain_t val);
    in_bus.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.wdata <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      spid_pkg::REG_PGAIN: kp = val;
      spid_pkg::REG_IGAIN: ki = val;
      spid_pkg::REG_DGAIN: kd = val;
      default: ;
    endcase
    gain_writes++;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item; predict its drive value at the accepting edge.
  task automatic send_item(sample_t setpoint, sample_t position);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.reference   <= setpoint;
    in_bus.measurement <= position;
    do @(posedge clk); while (!in_bus.ready);
    drive_q.push_back(pid_drive(setpoint, position));
    items_sent++;
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // All gains zero: drive stays at zero even at the widest error
  task automatic test_zero_gains();
    write_gain(spid_pkg::REG_PGAIN, '0);
    write_gain(spid_pkg::REG_IGAIN, '0);
    write_gain(spid_pkg::REG_DGAIN, '0);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sh0000, 16'sh0000);
  endtask

  // Largest integral gain gives the tightest limit; hit it both ways, then
  // come back inside it.
  task automatic test_integral_clamp();
    write_gain(spid_pkg::REG_IGAIN, '1);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sd100, 16'sd0);
  endtask

  // Wind the sum up under a zero gain, then raise the gain: the stored sum
  // is kept and clamps against the new limit on the next item.
  task automatic test_gain_change();
    write_gain(spid_pkg::REG_IGAIN, '0);
    repeat (3) send_item(16'sd30000, -16'sd30000);
    write_gain(spid_pkg::REG_IGAIN, '1);
    send_item(16'sd0, 16'sd0);
    write_gain(spid_pkg::REG_IGAIN, 15'd1);
    send_item(16'sd0, 16'sd0);
  endtask

  // Unit proportional gain: small totals of either sign must round toward zero
  task automatic test_truncation();
    write_gain(spid_pkg::REG_IGAIN, '0);
    write_gain(spid_pkg::REG_PGAIN, 15'd1);
    send_item(16'sd0, 16'sd1);
    send_item(16'sd0, 16'sd129);
    send_item(16'sd0, -16'sd127);
    send_item(16'sd0, -16'sd128);
  endtask

  // All gains at maximum: the sum of the terms passes 32 bits and the drive
  // must clamp at both rails, never wrap.
  task automatic test_full_width();
    write_gain(spid_pkg::REG_PGAIN, '1);
    write_gain(spid_pkg::REG_IGAIN, '1);
    write_gain(spid_pkg::REG_DGAIN, '1);
    send_item(16'sh7FFF, 16'sh8000);
    send_item(16'sh8000, 16'sh7FFF);
    send_item(16'sh8000, 16'sh8000);
    send_item(16'sh0000, 16'sh0000);
  endtask

  // Write to the unused index, then check the gains are untouched
  task automatic test_unused_index();
    write_gain(REG_SPARE, '1);
    write_gain(REG_SPARE, 15'h2AAA);
    send_item(16'sh1234, -16'sh0F0F);
  endtask

  // --------------------------------------------------------------------------
  // Random test
  // --------------------------------------------------------------------------

  function automatic gain_t pick_gain();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return gain_t'($urandom_range(1, 15));
      3: return gain_t'($urandom_range(16, 1023));
      default: return gain_t'($urandom);
    endcase
  endfunction

  function automatic sample_t corner_value();
    case ($urandom_range(0, 4))
      0: return 16'sh8000;
      1: return -16'sd1;
      2: return 16'sd0;
      3: return 16'sd1;
      default: return 16'sh7FFF;
    endcase
  endfunction

  // Mostly a loop tracking a wandering setpoint (small errors, integral
  // stays inside its limit), with full-range noise, corner values and rail-to-rail steps.
  task automatic send_random_item();
    int      pick;
    sample_t setpoint, position;
    pick = $urandom_range(0, 7);
    if (pick < 4) begin
      track_pos = to_sample(track_pos + int'($urandom_range(0, 2000)) - 1000);
      setpoint  = sample_t'(track_pos);
      position  = to_sample(track_pos + int'($urandom_range(0, 800)) - 400);
    end else if (pick < 6) begin
      setpoint = sample_t'($urandom);
      position = sample_t'($urandom);
    end else if (pick == 6) begin
      setpoint = corner_value();
      position = corner_value();
    end else if ($urandom_range(0, 1) == 1) begin
      setpoint = 16'sh7FFF;
      position = 16'sh8000;
    end else begin
      setpoint = 16'sh8000;
      position = 16'sh7FFF;
    end
    send_item(setpoint, position);
  endtask

  task automatic test_random_mix();
    int ph;
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      no_idle = (ph % 4 == 3);
      write_gain(spid_pkg::REG_PGAIN, pick_gain());
      write_gain(spid_pkg::REG_IGAIN, pick_gain());
      write_gain(spid_pkg::REG_DGAIN, pick_gain());
      if (ph % 5 == 4) write_gain(REG_SPARE, gain_t'($urandom));
      repeat (ITEMS_PER_PHASE) send_random_item();
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: random back-pressure, in-order compare
  // --------------------------------------------------------------------------
  initial begin : result_check
    int      stall;
    sample_t want;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_wait();
      if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      results_seen++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected drive item %0d: %0d", results_seen, out_bus.drive);
      end else begin
        want = drive_q.pop_front();
        if (out_bus.drive !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("drive mismatch on item %0d: expected %0d, got %0d",
                     results_seen, want, out_bus.drive);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.index       = '0;
    cfg_bus.wdata       = '0;
    in_bus.valid        = 1'b0;
    in_bus.reference    = '0;
    in_bus.measurement  = '0;
    kp                  = '0;
    ki                  = '0;
    kd                  = '0;
    err_sum             = 0;
    last_meas           = '0;
    no_idle             = 1'b0;
    track_pos           = 0;
    items_sent          = 0;
    results_seen        = 0;
    mismatches          = 0;
    gain_writes         = 0;
    clamp_hits          = 0;
    rail_hits           = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_gains();
    test_integral_clamp();
    test_gain_change();
    test_truncation();
    test_full_width();
    test_unused_index();
    test_random_mix();

    in_bus.valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d items across %0d gain writes, checked %0d drive values.",
             items_sent, gain_writes, results_seen);
    $display("Integral sum clamped %0d times; drive sat on a rail %0d times.",
             clamp_hits, rail_hits);
    if (drive_q.size() != 0)
      $display("%0d predicted drive values never arrived", drive_q.size());
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin : watchdog
    #10_000_000;
    $display("timeout: %0d items sent, %0d results seen", items_sent, results_seen);
    $display("tb failed");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/spid_pkg.sv
rtl/spid_in_if.sv
rtl/spid_out_if.sv
rtl/spid_cfg_if.sv
rtl/spid_mdu.sv
rtl/saturating_pid_controller_core.sv
tb/tb.sv
